[rtl/dtmf_pkg.sv]
// Shared types and constants for the DTMF tone synthesizer.
// Holds the request/result payload structs and the 256-entry sine table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtmf_pkg;

  localparam int unsigned CodeW  = 4;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned PhaseW = 8;
  localparam int unsigned TicksW = 16;

  localparam logic [TicksW-1:0] ToneTicksRst = 16'd6250;

  localparam logic [CodeW-1:0] CodeStar = 4'd10;
  localparam logic [CodeW-1:0] CodeHash = 4'd11;

  typedef struct packed {
    logic             digit_pending;
    logic [CodeW-1:0] digit_code;
  } dtmf_req_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             digit_taken;
    logic             busy_res;
  } dtmf_res_t;

  localparam logic [DutyW-1:0] SineTab [256] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd178, 8'd181, 8'd184, 8'd187, 8'd190, 8'd192, 8'd195,
    8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd212, 8'd215,
    8'd217, 8'd219, 8'd221, 8'd223, 8'd225, 8'd227, 8'd229, 8'd231,
    8'd233, 8'd234, 8'd236, 8'd238, 8'd239, 8'd240, 8'd242, 8'd243,
    8'd244, 8'd245, 8'd247, 8'd248, 8'd249, 8'd249, 8'd250, 8'd251,
    8'd252, 8'd252, 8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253, 8'd253, 8'd252,
    8'd252, 8'd251, 8'd250, 8'd249, 8'd249, 8'd248, 8'd247, 8'd245,
    8'd244, 8'd243, 8'd242, 8'd240, 8'd239, 8'd238, 8'd236, 8'd234,
    8'd233, 8'd231, 8'd229, 8'd227, 8'd225, 8'd223, 8'd221, 8'd219,
    8'd217, 8'd215, 8'd212, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
    8'd198, 8'd195, 8'd192, 8'd190, 8'd187, 8'd184, 8'd181, 8'd178,
    8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
    8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
    8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
    8'd78,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,  8'd59,
    8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,  8'd39,
    8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
    8'd21,  8'd20,  8'd18,  8'd16,  8'd15,  8'd14,  8'd12,  8'd11,
    8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
    8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
    8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd16,  8'd18,  8'd20,
    8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
    8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
    8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,
    8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
    8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
  };

endpackage

`default_nettype wire

[rtl/dtmf_core.sv]
// Tone state and per-tick sample computation for the DTMF synthesizer.
// Holds phases, steps, tick counter and held duty; uses dtmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtmf_core import dtmf_pkg::*; #(
  parameter int unsigned SampleRateHz = 62500
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire dtmf_req_t         req_i,
  input  wire logic [TicksW-1:0] tone_ticks_i,
  output dtmf_res_t              res_o
);

  localparam logic [PhaseW-1:0] StepC1209 =
    PhaseW'((512 * 1209 + SampleRateHz) / (2 * SampleRateHz));
  localparam logic [PhaseW-1:0] StepC1336 =
    PhaseW'((512 * 1336 + SampleRateHz) / (2 * SampleRateHz));
  localparam logic [PhaseW-1:0] StepC1477 =
    PhaseW'((512 * 1477 + SampleRateHz) / (2 * SampleRateHz));
  localparam logic [PhaseW-1:0] StepR697 =
    PhaseW'((512 * 697 + SampleRateHz) / (2 * SampleRateHz));
  localparam logic [PhaseW-1:0] StepR770 =
    PhaseW'((512 * 770 + SampleRateHz) / (2 * SampleRateHz));
  localparam logic [PhaseW-1:0] StepR852 =
    PhaseW'((512 * 852 + SampleRateHz) / (2 * SampleRateHz));
  localparam logic [PhaseW-1:0] StepR941 =
    PhaseW'((512 * 941 + SampleRateHz) / (2 * SampleRateHz));

  logic [PhaseW-1:0] high_phase_q, high_phase_d;
  logic [PhaseW-1:0] low_phase_q, low_phase_d;
  logic [PhaseW-1:0] high_step_q, high_step_d;
  logic [PhaseW-1:0] low_step_q, low_step_d;
  logic [TicksW-1:0] ticks_left_q, ticks_left_d;
  logic              armed_q, armed_d;
  logic [DutyW-1:0]  duty_q, duty_d;

  logic [PhaseW-1:0] col_step, row_step;
  logic              code_ok;
  logic [DutyW:0]    sine_sum;
  logic              taken, busy;

  always_comb begin
    code_ok  = 1'b1;
    col_step = StepC1336;
    row_step = StepR941;
    unique case (req_i.digit_code)
      4'd0: begin col_step = StepC1336; row_step = StepR941; end
      4'd1: begin col_step = StepC1209; row_step = StepR697; end
      4'd2: begin col_step = StepC1336; row_step = StepR697; end
      4'd3: begin col_step = StepC1477; row_step = StepR697; end
      4'd4: begin col_step = StepC1209; row_step = StepR770; end
      4'd5: begin col_step = StepC1336; row_step = StepR770; end
      4'd6: begin col_step = StepC1477; row_step = StepR770; end
      4'd7: begin col_step = StepC1209; row_step = StepR852; end
      4'd8: begin col_step = StepC1336; row_step = StepR852; end
      4'd9: begin col_step = StepC1477; row_step = StepR852; end
      CodeStar: begin col_step = StepC1209; row_step = StepR941; end
      CodeHash: begin col_step = StepC1477; row_step = StepR941; end
      default: code_ok = 1'b0;
    endcase
  end

  assign sine_sum = {1'b0, SineTab[high_phase_q]} + {1'b0, SineTab[low_phase_q]};

  always_comb begin
    high_phase_d = high_phase_q;
    low_phase_d  = low_phase_q;
    high_step_d  = high_step_q;
    low_step_d   = low_step_q;
    ticks_left_d = ticks_left_q;
    armed_d      = armed_q;
    duty_d       = duty_q;
    taken        = 1'b0;
    busy         = 1'b0;
    priority if (armed_q) begin
      busy = 1'b1;
      if (ticks_left_q == '0) begin
        duty_d  = '0;
        armed_d = 1'b0;
      end else begin
        duty_d       = sine_sum[DutyW:1];
        high_phase_d = high_phase_q + high_step_q;
        low_phase_d  = low_phase_q + low_step_q;
        ticks_left_d = ticks_left_q - 1'b1;
      end
    end else if (req_i.digit_pending && code_ok) begin
      high_step_d  = col_step;
      low_step_d   = row_step;
      high_phase_d = '0;
      low_phase_d  = '0;
      ticks_left_d = tone_ticks_i;
      armed_d      = 1'b1;
      taken        = 1'b1;
      busy         = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_phase_q <= '0;
      low_phase_q  <= '0;
      high_step_q  <= '0;
      low_step_q   <= '0;
      ticks_left_q <= '0;
      armed_q      <= 1'b0;
      duty_q       <= '0;
    end else if (advance_i) begin
      high_phase_q <= high_phase_d;
      low_phase_q  <= low_phase_d;
      high_step_q  <= high_step_d;
      low_step_q   <= low_step_d;
      ticks_left_q <= ticks_left_d;
      armed_q      <= armed_d;
      duty_q       <= duty_d;
    end
  end

  assign res_o.duty        = duty_d;
  assign res_o.digit_taken = taken;
  assign res_o.busy_res    = busy;

endmodule

`default_nettype wire

[rtl/dtmf_tone_synth_unit.sv]
// DTMF tone synthesizer top level: request register, tone core, result register.
// Instantiates dtmf_core; uses dtmf_pkg.
//
// Usage:
//   Each request on the in channel (valid/ready) is one sample tick carrying
//   digit_pending and digit_code. Each request yields exactly one result on the
//   out channel (valid/ready): the PWM duty after that tick, whether the pending
//   digit was taken, and whether a tone is armed or ending.
//   Path: an accepted request goes into the request register, then the result
//   register, which drives out_valid_o and out_res_o.
//   Throughput: one request per cycle while out_ready_i is high; a tick's sine
//   reads, phase adds and count update are combinational between the registers.
//   Stall: when out_ready_i is low the result register holds; one more request
//   is still taken into the request register, after which in_ready_o drops.
//   tone_ticks is written through cfg_we_i/cfg_wdata_i and applies to digits
//   taken afterwards.
//   Reset: both pipeline stages empty, block idle, duty 0, tone_ticks 6250.
`timescale 1ns / 1ps
`default_nettype none

module dtmf_tone_synth_unit import dtmf_pkg::*; #(
  parameter int unsigned SAMPLE_RATE_HZ = 62500
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dtmf_req_t         in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dtmf_res_t              out_res_o,
  input  wire logic              cfg_we_i,
  input  wire logic [TicksW-1:0] cfg_wdata_i
);

  logic              req_valid_q;
  dtmf_req_t         req_q;
  logic              res_valid_q;
  dtmf_res_t         res_q, res_d;
  logic [TicksW-1:0] tone_ticks_q;
  logic              stage_adv;

  assign stage_adv  = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || stage_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_ticks_q <= ToneTicksRst;
    end else if (cfg_we_i) begin
      tone_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  dtmf_core #(
    .SampleRateHz (SAMPLE_RATE_HZ)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (stage_adv),
    .req_i        (req_q),
    .tone_ticks_i (tone_ticks_q),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (stage_adv) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

[rtl/dtmf_chk.sv]
// Port-level checks for dtmf_tone_synth_unit, attached by bind.
// Uses dtmf_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

module dtmf_chk import dtmf_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire dtmf_res_t out_res_o
);

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("in_ready_o low without a waiting result");

  a_taken_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.digit_taken |-> out_res_o.busy_res)
    else $error("digit taken without busy");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a request two cycles earlier");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result dropped or changed");

endmodule

bind dtmf_tone_synth_unit dtmf_chk u_dtmf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);

`default_nettype wire
